FILE: rtl/cstr_esc_pkg.sv
// ----------------------------------------------------------------------------
// cstr_esc_pkg: C string literal escaper types and constants
// Character codes and the per-byte escape expansion shared by the escaper.
// ----------------------------------------------------------------------------
package cstr_esc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned MaxOut = 6;
  localparam int unsigned CntW   = 3;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChBs    = 8'h08;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChBel   = 8'h07;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDel   = 8'h7F;
  localparam logic [7:0] ChHigh  = 8'h80;
  localparam logic [7:0] TagN    = 8'h6E;
  localparam logic [7:0] TagR    = 8'h72;
  localparam logic [7:0] TagT    = 8'h74;
  localparam logic [7:0] TagB    = 8'h62;
  localparam logic [7:0] TagF    = 8'h66;
  localparam logic [7:0] TagV    = 8'h76;
  localparam logic [7:0] TagA    = 8'h61;

  // Up to four bytes from one escaped character, byte 0 first.
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } esc_seg_t;

  function automatic esc_seg_t escape_char(input logic [7:0] c);
    esc_seg_t   s;
    logic [7:0] tag;
    s   = '0;
    tag = '0;
    unique case (c)
      ChQuote:  tag = ChQuote;
      ChBslash: tag = ChBslash;
      ChNl:     tag = TagN;
      ChCr:     tag = TagR;
      ChTab:    tag = TagT;
      ChBs:     tag = TagB;
      ChFf:     tag = TagF;
      ChVt:     tag = TagV;
      ChBel:    tag = TagA;
      default:  tag = '0;
    endcase
    if (tag != 8'd0) begin
      s.b[0] = ChBslash;
      s.b[1] = tag;
      s.n    = 3'd2;
    end else if (c < ChSpace || c == ChDel || c >= ChHigh) begin
      s.b[0] = ChBslash;
      s.b[1] = ChZero + {6'd0, c[7:6]};
      s.b[2] = ChZero + {5'd0, c[5:3]};
      s.b[3] = ChZero + {5'd0, c[2:0]};
      s.n    = 3'd4;
    end else begin
      s.b[0] = c;
      s.n    = 3'd1;
    end
    return s;
  endfunction

endpackage

FILE: rtl/c_string_literal_escaper.sv
// ----------------------------------------------------------------------------
// c_string_literal_escaper: byte stream to C string literal body
// Expands each raw byte into its escaped form and streams the result bytes.
// ----------------------------------------------------------------------------
// Timing: the first result byte of an input transfer is valid in the cycle after it.
// Throughput: one input byte per cycle while each byte expands to one result and
//   out_stall is low; a byte expanding to n results occupies the result buffer
//   until the single result port drains them, one byte per cycle when not stalled.
// Reset (rst_n, synchronous, active low): empties the result buffer and drops
//   any held question mark.

module c_string_literal_escaper (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_string_end,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_run_last
);

  // Result buffer: bytes shift out from the bottom, rem_r counts what is left.
  logic [cstr_esc_pkg::MaxOut-1:0][7:0] buf_r, buf_nxt;
  logic [cstr_esc_pkg::CntW-1:0]        rem_r, rem_nxt;
  // Trigraph guard state.
  logic                                 q_held_r, q_held_nxt;
  logic                                 held_esc_r, held_esc_nxt;

  logic                                 in_xfer;
  logic                                 out_xfer;
  logic                                 is_q;
  logic [1:0][7:0]                      pre_b;
  logic [1:0]                           pre_n;
  cstr_esc_pkg::esc_seg_t               tail;
  cstr_esc_pkg::esc_seg_t               esc;
  logic [cstr_esc_pkg::MaxOut-1:0][7:0] exp_b;
  logic [cstr_esc_pkg::CntW-1:0]        exp_n;

  assign out_valid    = (rem_r != '0);
  assign out_char_out = buf_r[0];
  assign out_run_last = (rem_r == 3'd1);
  assign out_xfer     = out_valid && !out_stall;

  // Accept when the buffer is empty or its last byte leaves this cycle.
  assign in_stall = out_valid && !(out_run_last && !out_stall);
  assign in_xfer  = in_valid && !in_stall;

  assign is_q = (in_char_in == cstr_esc_pkg::ChQmark);
  assign esc  = cstr_esc_pkg::escape_char(in_char_in);

  // Expansion: an optional flushed question mark, then the new byte's part.
  always_comb begin
    pre_b = '0;
    pre_n = 2'd0;
    tail  = '0;
    if (q_held_r) begin
      // A held mark next to another mark always takes the escape.
      if (held_esc_r || is_q) begin
        pre_b[0] = cstr_esc_pkg::ChBslash;
        pre_b[1] = cstr_esc_pkg::ChQmark;
        pre_n    = 2'd2;
      end else begin
        pre_b[0] = cstr_esc_pkg::ChQmark;
        pre_n    = 2'd1;
      end
      if (is_q) begin
        if (in_string_end) begin
          tail.b[0] = cstr_esc_pkg::ChBslash;
          tail.b[1] = cstr_esc_pkg::ChQmark;
          tail.n    = 3'd2;
        end
      end else begin
        tail = esc;
      end
    end else if (is_q) begin
      // A lone mark is held unless it ends the string.
      if (in_string_end) begin
        tail.b[0] = cstr_esc_pkg::ChQmark;
        tail.n    = 3'd1;
      end
    end else begin
      tail = esc;
    end

    unique case (pre_n)
      2'd1:    exp_b = {8'd0, tail.b, pre_b[0]};
      2'd2:    exp_b = {tail.b, pre_b[1], pre_b[0]};
      default: exp_b = {16'd0, tail.b};
    endcase
    exp_n = {1'b0, pre_n} + tail.n;
  end

  always_comb begin
    buf_nxt      = buf_r;
    rem_nxt      = rem_r;
    q_held_nxt   = q_held_r;
    held_esc_nxt = held_esc_r;
    if (out_xfer) begin
      // Advance to the next byte.
      buf_nxt = buf_r >> cstr_esc_pkg::ByteW;
      rem_nxt = rem_r - 3'd1;
    end
    if (in_xfer) begin
      // Load the new expansion; a zero count leaves the buffer empty.
      buf_nxt      = exp_b;
      rem_nxt      = exp_n;
      q_held_nxt   = is_q && !in_string_end;
      held_esc_nxt = is_q && !in_string_end && q_held_r;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (!rst_n) begin
      rem_r      <= '0;
      q_held_r   <= 1'b0;
      held_esc_r <= 1'b0;
    end else begin
      rem_r      <= rem_nxt;
      q_held_r   <= q_held_nxt;
      held_esc_r <= held_esc_nxt;
    end
  end

  // Buffer never counts more than it can hold.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'd6)
    else $error("result count out of range");

  // A transfer of a non-final byte drains exactly one byte.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && rem_r > 3'd1 |=> rem_r == $past(rem_r) - 3'd1)
    else $error("result buffer drain mismatch");

  // Nothing stays held past the end of a string.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_string_end |=> !q_held_r)
    else $error("question mark held across string end");

  // The escape flag only qualifies a held mark.
  a_esc_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    held_esc_r |-> q_held_r)
    else $error("escape flag set with nothing held");

endmodule

FILE: verif/c_string_literal_escaper_checker.sv
// ----------------------------------------------------------------------------
// c_string_literal_escaper_checker: escaped literal predictor and scoreboard
// Watches both channels, predicts the literal body bytes for every input
// transfer and compares each result transfer against the oldest prediction.
// ----------------------------------------------------------------------------

module c_string_literal_escaper_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_string_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_char_out,
  input  logic        out_run_last,
  output int unsigned fail_count,
  output int unsigned backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } lit_byte_t;

  lit_byte_t literal_q[$];
  logic      q_held;
  logic      q_follows_q;

  function automatic void emit(input logic [7:0] ch);
    lit_byte_t b;
    b.ch   = ch;
    b.last = 1'b0;
    literal_q.push_back(b);
  endfunction

  function automatic void emit_char(input logic [7:0] c);
    logic [7:0] tag;
    case (c)
      cstr_esc_pkg::ChQuote, cstr_esc_pkg::ChBslash: tag = c;
      cstr_esc_pkg::ChNl:  tag = cstr_esc_pkg::TagN;
      cstr_esc_pkg::ChCr:  tag = cstr_esc_pkg::TagR;
      cstr_esc_pkg::ChTab: tag = cstr_esc_pkg::TagT;
      cstr_esc_pkg::ChBs:  tag = cstr_esc_pkg::TagB;
      cstr_esc_pkg::ChFf:  tag = cstr_esc_pkg::TagF;
      cstr_esc_pkg::ChVt:  tag = cstr_esc_pkg::TagV;
      cstr_esc_pkg::ChBel: tag = cstr_esc_pkg::TagA;
      default:             tag = 8'h00;
    endcase
    if (tag != 8'h00) begin
      emit(cstr_esc_pkg::ChBslash);
      emit(tag);
    end else if (c < cstr_esc_pkg::ChSpace || c >= cstr_esc_pkg::ChDel) begin
      // delete and every high byte fall in here along with the controls
      emit(cstr_esc_pkg::ChBslash);
      for (int k = 2; k >= 0; k--) begin
        emit(cstr_esc_pkg::ChZero | ((c >> (3 * k)) & 8'h07));
      end
    end else begin
      emit(c);
    end
  endfunction

  function automatic void emit_question(input logic escaped);
    if (escaped) begin
      emit(cstr_esc_pkg::ChBslash);
    end
    emit(cstr_esc_pkg::ChQmark);
  endfunction

  function automatic void predict_literal(input logic [7:0] c, input logic str_end);
    int unsigned first;
    lit_byte_t   tail;
    first = literal_q.size();
    if (q_held) begin
      if (c == cstr_esc_pkg::ChQmark) begin
        emit_question(1'b1);
        if (str_end) begin
          emit_question(1'b1);
          q_held      = 1'b0;
          q_follows_q = 1'b0;
        end else begin
          q_follows_q = 1'b1;
        end
      end else begin
        emit_question(q_follows_q);
        emit_char(c);
        q_held      = 1'b0;
        q_follows_q = 1'b0;
      end
    end else if (c == cstr_esc_pkg::ChQmark) begin
      if (str_end) begin
        emit_question(1'b0);
      end else begin
        q_held      = 1'b1;
        q_follows_q = 1'b0;
      end
    end else begin
      emit_char(c);
    end
    // mark the final byte this transfer produced, if any
    if (literal_q.size() > first) begin
      tail      = literal_q.pop_back();
      tail.last = 1'b1;
      literal_q.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    lit_byte_t want;
    if (!rst_n) begin
      q_held      = 1'b0;
      q_follows_q = 1'b0;
      fail_count  = 0;
      literal_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (literal_q.size() == 0) begin
          $error("char_out: expected nothing, got %02h", out_char_out);
          fail_count++;
        end else begin
          want = literal_q.pop_front();
          if (out_char_out !== want.ch) begin
            $error("char_out: expected %02h, got %02h", want.ch, out_char_out);
            fail_count++;
          end
          if (out_run_last !== want.last) begin
            $error("run_last: expected %0b, got %0b", want.last, out_run_last);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_literal(in_char_in, in_string_end);
      end
    end
    backlog = literal_q.size();
  end

endmodule

FILE: verif/c_string_literal_escaper_test.sv
// ----------------------------------------------------------------------------
// c_string_literal_escaper_test: escaper testbench top
// Drives strings through the escaper, directed corner cases first and then
// random strings rich in question marks, with random gaps and back-pressure.
// ----------------------------------------------------------------------------

module c_string_literal_escaper_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned TotalBytes  = 150;   // 25 directed, the rest random
  localparam int unsigned IdleMax     = 19;
  localparam int unsigned QuietLimit  = 4000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumSpecials = 11;
  localparam logic [7:0] Specials [NumSpecials] = '{
    cstr_esc_pkg::ChQuote, cstr_esc_pkg::ChBslash, cstr_esc_pkg::ChNl,
    cstr_esc_pkg::ChCr, cstr_esc_pkg::ChTab, cstr_esc_pkg::ChBs, cstr_esc_pkg::ChFf,
    cstr_esc_pkg::ChVt, cstr_esc_pkg::ChBel, cstr_esc_pkg::ChDel, cstr_esc_pkg::ChSpace
  };

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_in;
  logic       in_string_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char_out;
  logic       out_run_last;

  int unsigned mismatch_count;
  int unsigned backlog;
  int unsigned byte_count;
  int unsigned string_count;
  int unsigned literal_count;
  int unsigned quiet_cycles;
  bit          no_idle;     // both sides skip their gaps while set

  c_string_literal_escaper i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_in    (in_char_in),
    .in_string_end (in_string_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_out  (out_char_out),
    .out_run_last  (out_run_last)
  );

  c_string_literal_escaper_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_in    (in_char_in),
    .in_string_end (in_string_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_out  (out_char_out),
    .out_run_last  (out_run_last),
    .fail_count    (mismatch_count),
    .backlog       (backlog)
  );

  initial clk = 1'b0;
  always #5ns clk = ~clk;

  // Offer one byte after a random gap and hold it until the transfer.
  // A zero gap keeps valid high straight into the next byte.
  task automatic send_byte(input logic [7:0] c, input logic str_end);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, IdleMax);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_char_in    <= c;
    in_string_end <= str_end;
    do @(posedge clk); while (in_stall);
    byte_count++;
  endtask

  // Flag the last byte of the string as its end.
  task automatic send_string(input byte_q_t s);
    foreach (s[k]) begin
      send_byte(s[k], k == s.size() - 1);
    end
    string_count++;
  endtask

  // Mostly question marks and escape triggers, so held marks meet every kind
  // of follower; the rest is any byte at all.
  task automatic send_random_string();
    byte_q_t     s;
    int unsigned len;
    int unsigned pick;
    len = $urandom_range(1, 8);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        s.push_back(cstr_esc_pkg::ChQmark);
      end else if (pick < 6) begin
        s.push_back(Specials[$urandom_range(0, NumSpecials - 1)]);
      end else begin
        s.push_back(8'($urandom));
      end
    end
    send_string(s);
  endtask

  // Result side: stall for a random number of cycles, then release until the
  // next transfer goes through.
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, IdleMax);
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        literal_count++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout: no transfer for %0d cycles, %0d bytes pending",
                 QuietLimit, backlog);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    byte_q_t s;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_char_in    = 8'h00;
    in_string_end = 1'b0;
    no_idle       = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extremes of the byte range.
    s = '{8'h00, 8'hFF};
    send_string(s);
    // Every two-byte escape.
    s = '{cstr_esc_pkg::ChQuote, cstr_esc_pkg::ChBslash, cstr_esc_pkg::ChNl,
          cstr_esc_pkg::ChCr, cstr_esc_pkg::ChTab, cstr_esc_pkg::ChBs,
          cstr_esc_pkg::ChFf, cstr_esc_pkg::ChVt, cstr_esc_pkg::ChBel};
    send_string(s);
    // Octal borders and the printable edges around them.
    s = '{8'h1F, cstr_esc_pkg::ChDel, cstr_esc_pkg::ChHigh, cstr_esc_pkg::ChSpace, 8'h7E};
    send_string(s);
    // Lone mark that ends the string goes out bare.
    s = '{cstr_esc_pkg::ChQmark};
    send_string(s);
    // Held mark released by a plain byte.
    s = '{cstr_esc_pkg::ChQmark, 8'h41};
    send_string(s);
    // Pair of marks at the string end: both escaped.
    s = '{cstr_esc_pkg::ChQmark, cstr_esc_pkg::ChQmark};
    send_string(s);
    // Run of marks, then a control byte: the widest burst of results.
    s = '{cstr_esc_pkg::ChQmark, cstr_esc_pkg::ChQmark, cstr_esc_pkg::ChQmark, 8'h01};
    send_string(s);

    while (byte_count < TotalBytes) begin
      no_idle = ($urandom_range(0, 3) == 0);
      send_random_string();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (backlog != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);

    $display("run covered %0d bytes in %0d strings, %0d literal bytes checked",
             byte_count, string_count, literal_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
